/* hw/rtl/skbs_pkg.sv */
// ----------------------------------------------------------------------------
// skbs_pkg
// Shared widths, field positions and request codes of the sorted key table.
// ----------------------------------------------------------------------------
`default_nettype none

package skbs_pkg;

  localparam int TABLE_DEPTH   = 256;
  localparam int MAX_KEY_BYTES = 8;
  localparam int IDX_W         = $clog2(TABLE_DEPTH);

  // configuration registers
  localparam int CNT_W      = 9;
  localparam int KLEN_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN     = 2'd1;

  // input beat
  localparam int REQ_W  = 2;
  localparam int EIDX_W = 8;
  localparam int KEY_W  = 64;
  localparam int QLEN_W = 4;

  localparam int IN_EIDX_LSB = 0;
  localparam int IN_KEY_LSB  = IN_EIDX_LSB + EIDX_W;
  localparam int IN_QLEN_LSB = IN_KEY_LSB + KEY_W;
  localparam int IN_USED_W   = IN_QLEN_LSB + QLEN_W;
  localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

  localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CHECK  = 2'd2;

  // output beat
  localparam int MATCH_W       = 8;
  localparam int OUT_FOUND_BIT = 0;
  localparam int OUT_MATCH_LSB = 1;
  localparam int OUT_OK_BIT    = OUT_MATCH_LSB + MATCH_W;
  localparam int OUT_USED_W    = OUT_OK_BIT + 1;
  localparam int OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;

  typedef struct packed {
    logic               table_ok;
    logic [MATCH_W-1:0] match_index;
    logic               found;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/skbs_ram.sv */
// ----------------------------------------------------------------------------
// skbs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module skbs_ram #(
  parameter int Width = 64,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sorted_key_table_binary_search.sv */
// Flow: a write beat goes through the result state to the output register; a
//   lookup makes at most 9 probes over 256 entries, each one RAM read plus a
//   64-bit compare; a check reads up to entry_count entries (count capped at
//   256), one RAM read per entry. One item is in work at a time; the next is
//   taken once the result sits in the output register. Reset sets entry_count
//   to 0 and key_len to 1; the key RAM is not cleared.
// ----------------------------------------------------------------------------
// sorted_key_table_binary_search
// Key table in a RAM with binary-search lookup and a sorted-order check.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table_binary_search (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // entry_index, key_value, query_len, zero pad
  input  wire logic [skbs_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // req_type
  input  wire logic [skbs_pkg::REQ_W-1:0]        s_axis_tuser_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // found, match_index, table_ok, zero pad
  output logic      [skbs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [skbs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [skbs_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  import skbs_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PROBE  = 3'd1;
  localparam logic [2:0] ST_CMP    = 3'd2;
  localparam logic [2:0] ST_CHECK  = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  localparam logic signed [CNT_W:0] STEP_ONE = (CNT_W+1)'(1);

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  entry_count_q;
  logic [KLEN_W-1:0] key_len_q;

  logic signed [CNT_W:0] lo_q, lo_d, hi_q, hi_d;
  logic [IDX_W-1:0]      mid_q, mid_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  have_prev_q, have_prev_d;
  logic [KEY_W-1:0]      key_q, key_d;
  logic [KEY_W-1:0]      prev_q, prev_d;
  result_t               res_q, res_d;

  logic                  out_valid_q;
  result_t               out_q;

  logic [CNT_W-1:0]      used_n;
  logic [KLEN_W-1:0]     klen_c;
  logic [KEY_W-1:0]      mask;
  logic [KEY_W-1:0]      cur_key;
  logic [CNT_W:0]        mid_sum;
  logic                  in_fire, out_free;

  logic [REQ_W-1:0]      in_req;
  logic [EIDX_W-1:0]     in_eidx;
  logic [KEY_W-1:0]      in_key;
  logic [QLEN_W-1:0]     in_qlen;

  logic                  ram_we, ram_re;
  logic [IDX_W-1:0]      ram_raddr;
  logic [KEY_W-1:0]      ram_rdata;

  assign in_req  = s_axis_tuser_i;
  assign in_eidx = s_axis_tdata_i[IN_EIDX_LSB +: EIDX_W];
  assign in_key  = s_axis_tdata_i[IN_KEY_LSB +: KEY_W];
  assign in_qlen = s_axis_tdata_i[IN_QLEN_LSB +: QLEN_W];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign cfg_ready_o     = 1'b1;

  assign used_n = (entry_count_q > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : entry_count_q;
  assign klen_c = (key_len_q > KLEN_W'(MAX_KEY_BYTES)) ? KLEN_W'(MAX_KEY_BYTES) : key_len_q;

  always_comb begin
    for (int b = 0; b < KEY_W / 8; b++) begin
      mask[b*8 +: 8] = (KLEN_W'(b) < klen_c) ? 8'hFF : 8'h00;
    end
  end

  assign cur_key = ram_rdata & mask;
  assign mid_sum = lo_q + hi_q;

  // only table slot writes touch the RAM; reads come from the search and check
  assign ram_we = in_fire && (in_req == REQ_WRITE);

  skbs_ram #(
    .Width (KEY_W),
    .Depth (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (IDX_W'(in_eidx)),
    .wdata_i (in_key),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    cnt_d       = cnt_q;
    have_prev_d = have_prev_q;
    key_d       = key_q;
    prev_d      = prev_q;
    res_d       = res_q;
    ram_re      = 1'b0;
    ram_raddr   = mid_sum[IDX_W:1];

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          res_d   = '0;
          state_d = ST_RESULT;
          key_d   = in_key & mask;
          case (in_req)
            REQ_LOOKUP: begin
              if ((in_qlen == key_len_q) && (used_n != '0)) begin
                lo_d    = '0;
                hi_d    = $signed({1'b0, used_n}) - STEP_ONE;
                state_d = ST_PROBE;
              end
            end
            REQ_CHECK: begin
              if ((used_n != '0) && (key_len_q != '0)) begin
                // fetch entry 0 now, stream the rest one per cycle
                ram_re      = 1'b1;
                ram_raddr   = '0;
                cnt_d       = CNT_W'(1);
                have_prev_d = 1'b0;
                state_d     = ST_CHECK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_PROBE: begin
        if (lo_q <= hi_q) begin
          ram_re  = 1'b1;
          mid_d   = mid_sum[IDX_W:1];
          state_d = ST_CMP;
        end else begin
          state_d = ST_RESULT;
        end
      end

      ST_CMP: begin
        if (key_q == cur_key) begin
          res_d.found       = 1'b1;
          res_d.match_index = MATCH_W'(mid_q);
          state_d           = ST_RESULT;
        end else begin
          if (key_q > cur_key) begin
            lo_d = $signed({2'b00, mid_q}) + STEP_ONE;
          end else begin
            hi_d = $signed({2'b00, mid_q}) - STEP_ONE;
          end
          state_d = ST_PROBE;
        end
      end

      ST_CHECK: begin
        // ram_rdata holds entry cnt_q - 1
        prev_d      = cur_key;
        have_prev_d = 1'b1;
        if (have_prev_q && (prev_q > cur_key)) begin
          state_d = ST_RESULT;
        end else if (cnt_q == used_n) begin
          res_d.table_ok = 1'b1;
          state_d        = ST_RESULT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = cnt_q[IDX_W-1:0];
          cnt_d     = cnt_q + 1'b1;
        end
      end

      ST_RESULT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      entry_count_q <= '0;
      key_len_q     <= KLEN_W'(1);
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && (cfg_index_i == CFG_ENTRY_COUNT)) begin
        entry_count_q <= CNT_W'(cfg_data_i);
      end
      if (cfg_valid_i && (cfg_index_i == CFG_KEY_LEN)) begin
        key_len_q <= cfg_data_i[KLEN_W-1:0];
      end
      if ((state_q == ST_RESULT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    cnt_q       <= cnt_d;
    have_prev_q <= have_prev_d;
    key_q       <= key_d;
    prev_q      <= prev_d;
    res_q       <= res_d;
    if ((state_q == ST_RESULT) && out_free) begin
      out_q <= res_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(out_q);

endmodule

`default_nettype wire

/* hw/rtl/skbs_checker.sv */
// ----------------------------------------------------------------------------
// skbs_checker
// Port-level checks of the sorted key table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module skbs_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tvalid_i,
  input wire logic                              s_axis_tready_o,
  input wire logic [skbs_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  input wire logic [skbs_pkg::REQ_W-1:0]        s_axis_tuser_i,
  input wire logic                              m_axis_tvalid_o,
  input wire logic                              m_axis_tready_i,
  input wire logic [skbs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  input wire logic                              cfg_valid_i,
  input wire logic                              cfg_ready_o,
  input wire logic [skbs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input wire logic [skbs_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  import skbs_pkg::*;

  logic               out_found, out_ok;
  logic [MATCH_W-1:0] out_match;

  assign out_found = m_axis_tdata_o[OUT_FOUND_BIT];
  assign out_ok    = m_axis_tdata_o[OUT_OK_BIT];
  assign out_match = m_axis_tdata_o[OUT_MATCH_LSB +: MATCH_W];

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat dropped or changed while stalled");

  // a lookup hit and a check pass never share one beat
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(out_found && out_ok))
    else $error("found and table_ok both set");

  a_miss_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !out_found |-> out_match == '0)
    else $error("match_index nonzero on a miss");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while an item is still in work");

endmodule

bind sorted_key_table_binary_search skbs_checker u_skbs_checker (.*);

`default_nettype wire

/* verif/sorted_key_table_binary_search_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_binary_search_test
// Loads the key table with sorted and broken content under many entry counts
// and key lengths, then runs lookups, order checks and stray requests against
// a mirror of the table that predicts every result beat.
// ----------------------------------------------------------------------------

module sorted_key_table_binary_search_test;
  import skbs_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
  localparam int TARGET_ITEMS = 1650;
  localparam int CALM_TAIL    = 150;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 2500000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [REQ_W-1:0]       s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // mirror of the block state
  logic [KEY_W-1:0]  key_mirror [TABLE_DEPTH];
  logic [CNT_W-1:0]  count_mirror;
  logic [KLEN_W-1:0] klen_mirror;

  result_t pending_results [$];
  result_t got_result;
  result_t want_result;
  int      mismatch_count = 0;
  int      items_sent     = 0;
  int      cycle_count    = 0;
  int      stall_left     = 0;
  bit      calm           = 1'b0;

  sorted_key_table_binary_search dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [KEY_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [KEY_W-1:0] compare_mask(input logic [KLEN_W-1:0] klen);
    int nbytes;
    nbytes = (klen > MAX_KEY_BYTES) ? MAX_KEY_BYTES : int'(klen);
    if (nbytes >= 8) return '1;
    return (64'd1 << (8 * nbytes)) - 64'd1;
  endfunction

  function automatic int used_entries();
    return (count_mirror > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_mirror);
  endfunction

  // Apply one request to the mirror and return the beat it must produce.
  function automatic result_t table_response(input logic [REQ_W-1:0] req,
                                             input logic [EIDX_W-1:0] slot,
                                             input logic [KEY_W-1:0] key,
                                             input logic [QLEN_W-1:0] qlen);
    result_t          r;
    int               used;
    int               lo;
    int               hi;
    int               mid;
    int               i;
    logic [KEY_W-1:0] m;
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] e;
    r    = '0;
    used = used_entries();
    m    = compare_mask(klen_mirror);
    case (req)
      REQ_WRITE: begin
        key_mirror[slot] = key;
      end
      REQ_LOOKUP: begin
        if (qlen == klen_mirror && used != 0) begin
          lo = 0;
          hi = used - 1;
          k  = key & m;
          while (lo <= hi && !r.found) begin
            mid = (lo + hi) / 2;
            e   = key_mirror[mid] & m;
            if (k == e) begin
              r.found       = 1'b1;
              r.match_index = mid[MATCH_W-1:0];
            end else if (k > e) begin
              lo = mid + 1;
            end else begin
              hi = mid - 1;
            end
          end
        end
      end
      REQ_CHECK: begin
        if (used != 0 && klen_mirror != 0) begin
          r.table_ok = 1'b1;
          for (i = 0; i + 1 < used; i++) begin
            if ((key_mirror[i] & m) > (key_mirror[i + 1] & m)) r.table_ok = 1'b0;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_result.found       = m_axis_tdata[OUT_FOUND_BIT];
      got_result.match_index = m_axis_tdata[OUT_MATCH_LSB +: MATCH_W];
      got_result.table_ok    = m_axis_tdata[OUT_OK_BIT];
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result beat %h", m_axis_tdata));
      end else begin
        want_result = pending_results.pop_front();
        if (got_result.found !== want_result.found ||
            got_result.match_index !== want_result.match_index ||
            got_result.table_ok !== want_result.table_ok) begin
          note_mismatch($sformatf(
            "expected found %b index %0d ok %b, got found %b index %0d ok %b",
            want_result.found, want_result.match_index, want_result.table_ok,
            got_result.found, got_result.match_index, got_result.table_ok));
        end
      end
    end
  end

  // Result side: random stall bursts, none once the run turns calm.
  initial begin
    m_axis_tready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (calm) begin
        m_axis_tready = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready = 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left    = $urandom_range(1, 15) - 1;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at a falling edge with tvalid low.
  task automatic send_item(input logic [REQ_W-1:0] req, input int slot,
                           input logic [KEY_W-1:0] key, input logic [QLEN_W-1:0] qlen);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    s_axis_tvalid                              = 1'b1;
    s_axis_tuser                               = req;
    s_axis_tdata                               = '0;
    s_axis_tdata[IN_EIDX_LSB +: EIDX_W]        = slot[EIDX_W-1:0];
    s_axis_tdata[IN_KEY_LSB +: KEY_W]          = key;
    s_axis_tdata[IN_QLEN_LSB +: QLEN_W]        = qlen;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(table_response(req, slot[EIDX_W-1:0], key, qlen));
    items_sent++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // Write only with nothing in flight.
  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] value);
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = value;
    do @(posedge clk_i); while (!cfg_ready);
    if (index == CFG_ENTRY_COUNT) count_mirror = value;
    else if (index == CFG_KEY_LEN) klen_mirror = value[KLEN_W-1:0];
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  // Fill slots 0..n-1 with keys in non-decreasing order under the current key length,
  // with random bytes above the compared ones.
  task automatic load_sorted_table(input int n, input bit pin_ends);
    logic [KEY_W-1:0] m;
    logic [KEY_W-1:0] d;
    logic [KEY_W-1:0] v;
    logic [KEY_W-1:0] step;
    int               i;
    m = compare_mask(klen_mirror);
    d = m / (n + 1);
    v = pin_ends ? '0 : rand_word() % (d + 1);
    for (i = 0; i < n; i++) begin
      if (pin_ends && i == n - 1 && n > 1) v = m;
      send_item(REQ_WRITE, i, (rand_word() & ~m) | v, QLEN_W'($urandom_range(0, 15)));
      step = rand_word() % (2 * d + 1) + $urandom_range(0, 1);
      if (step > m - v) v = m;
      else v = v + step;
    end
  endtask

  // Look up the key held in a slot, with the uncompared bytes scrambled.
  task automatic lookup_slot(input int slot, input logic [QLEN_W-1:0] qlen);
    logic [KEY_W-1:0] m;
    m = compare_mask(klen_mirror);
    send_item(REQ_LOOKUP, $urandom_range(0, 255),
              (key_mirror[slot] & m) | (rand_word() & ~m), qlen);
  endtask

  task automatic test_fill_table();
    write_register(CFG_KEY_LEN, 9'd8);
    write_register(CFG_ENTRY_COUNT, 9'd256);
    load_sorted_table(TABLE_DEPTH, 1'b1);
  endtask

  task automatic test_lookup_extremes();
    lookup_slot(0, klen_mirror);
    lookup_slot(255, klen_mirror);
    lookup_slot(127, klen_mirror);
    send_item(REQ_LOOKUP, 255, rand_word(), klen_mirror);
    send_item(REQ_CHECK, 0, '0, '0);
  endtask

  task automatic test_order_break();
    logic [KEY_W-1:0] saved;
    saved = key_mirror[0];
    send_item(REQ_WRITE, 0, '1, 4'd15);
    send_item(REQ_CHECK, 255, '1, 4'd15);
    send_item(REQ_WRITE, 0, saved, '0);
    send_item(REQ_CHECK, 0, '0, '0);
  endtask

  task automatic test_mismatch_and_empty();
    lookup_slot(10, 4'd7);
    lookup_slot(10, 4'd0);
    lookup_slot(10, 4'd15);
    write_register(CFG_ENTRY_COUNT, 9'd0);
    lookup_slot(5, klen_mirror);
    send_item(REQ_CHECK, 0, '0, '0);
    // count above the depth clamps to the depth
    write_register(CFG_ENTRY_COUNT, 9'd511);
    lookup_slot(255, klen_mirror);
    send_item(REQ_CHECK, 0, '0, '0);
    write_register(CFG_ENTRY_COUNT, 9'd1);
    lookup_slot(0, klen_mirror);
    send_item(REQ_CHECK, 0, '0, '0);
    write_register(CFG_ENTRY_COUNT, 9'd256);
  endtask

  task automatic test_key_length_corners();
    // zero length: nothing compared, first probe matches
    write_register(CFG_KEY_LEN, 9'd0);
    send_item(REQ_CHECK, 0, '0, '0);
    send_item(REQ_LOOKUP, 0, rand_word(), 4'd0);
    send_item(REQ_LOOKUP, 0, rand_word(), 4'd1);
    // lengths beyond eight bytes compare eight
    write_register(CFG_KEY_LEN, 9'd15);
    lookup_slot(200, 4'd15);
    lookup_slot(200, 4'd8);
    send_item(REQ_CHECK, 0, '0, '0);
    write_register(CFG_KEY_LEN, 9'd8);
  endtask

  task automatic test_unknown_request();
    send_item(REQ_UNKNOWN, 255, '1, 4'd15);
    send_item(REQ_UNKNOWN, $urandom_range(0, 255), rand_word(), klen_mirror);
  endtask

  task automatic test_random_phases();
    int                            cnt;
    int                            klen;
    int                            used;
    int                            ops;
    int                            op;
    int                            pick;
    int                            i;
    logic [KEY_W-1:0]              m;
    logic [CFG_DATA_W-KLEN_W-1:0]  junk;
    while (items_sent < TARGET_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        case ($urandom_range(0, 6))
          0: cnt = 0;
          1: cnt = 1;
          2: cnt = 2;
          3: cnt = 255;
          4: cnt = 256;
          5: cnt = 257;
          default: cnt = 511;
        endcase
      end else if (pick <= 2) begin
        cnt = $urandom_range(33, 256);
      end else begin
        cnt = $urandom_range(1, 32);
      end
      if ($urandom_range(0, 7) == 0) klen = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(9, 15);
      else klen = $urandom_range(1, 8);
      // upper data bits of a key length write are dropped
      junk = (CFG_DATA_W - KLEN_W)'($urandom_range(0, 31));
      if ($urandom_range(0, 1) == 0) begin
        write_register(CFG_ENTRY_COUNT, cnt[CFG_DATA_W-1:0]);
        write_register(CFG_KEY_LEN, {junk, klen[KLEN_W-1:0]});
      end else begin
        write_register(CFG_KEY_LEN, {junk, klen[KLEN_W-1:0]});
        write_register(CFG_ENTRY_COUNT, cnt[CFG_DATA_W-1:0]);
      end
      used = used_entries();
      if ($urandom_range(0, 3) != 0) load_sorted_table(used, $urandom_range(0, 1));
      ops = $urandom_range(20, 60);
      for (i = 0; i < ops; i++) begin
        if (items_sent >= TARGET_ITEMS) break;
        if (items_sent >= TARGET_ITEMS - CALM_TAIL) calm = 1'b1;
        m  = compare_mask(klen_mirror);
        op = $urandom_range(0, 99);
        if (op < 55 && used > 0) begin
          lookup_slot($urandom_range(0, used - 1), klen_mirror);
        end else if (op < 70) begin
          if (used > 0 && $urandom_range(0, 1) == 0)
            send_item(REQ_LOOKUP, $urandom_range(0, 255),
                      key_mirror[$urandom_range(0, used - 1)] +
                      (($urandom_range(0, 1) == 0) ? 64'd1 : '1), klen_mirror);
          else
            send_item(REQ_LOOKUP, $urandom_range(0, 255), rand_word(), klen_mirror);
        end else if (op < 78) begin
          send_item(REQ_LOOKUP, $urandom_range(0, 255),
                    (used > 0) ? key_mirror[$urandom_range(0, used - 1)] : rand_word(),
                    QLEN_W'($urandom_range(0, 15)));
        end else if (op < 88) begin
          send_item(REQ_CHECK, $urandom_range(0, 255), rand_word(),
                    QLEN_W'($urandom_range(0, 15)));
        end else if (op < 95) begin
          send_item(REQ_WRITE, (used > 0) ? $urandom_range(0, used - 1) : $urandom_range(0, 255),
                    rand_word(), QLEN_W'($urandom_range(0, 15)));
        end else begin
          send_item(REQ_UNKNOWN, $urandom_range(0, 255), rand_word(),
                    QLEN_W'($urandom_range(0, 15)));
        end
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    count_mirror  = '0;
    klen_mirror   = 4'd1;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_fill_table();
    test_lookup_extremes();
    test_order_break();
    test_mismatch_and_empty();
    test_key_length_corners();
    test_unknown_request();
    test_random_phases();

    calm = 1'b1;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
